// ===== hdl/itfd_pkg.sv =====
// itfd_pkg: shared types, character codes and format codes for the
// formatted decimal text block. No dependencies.
`timescale 1ns / 1ps

package itfd_pkg;

  // digit layout of the bcd conversion
  localparam int NUM_DIGITS = 10;
  localparam int DIGIT_W    = 4;
  localparam int CONV_STEPS = 16;   // two magnitude bits per step
  localparam int QUEUE_DEPTH_DEF = 2;

  // format codes
  localparam logic [1:0] FMT_PLAIN   = 2'd0;
  localparam logic [1:0] FMT_DOLLAR  = 2'd1;
  localparam logic [1:0] FMT_PERCENT = 2'd2;
  localparam logic [1:0] FMT_NOSEP   = 2'd3;

  // fixed characters
  localparam logic [7:0] CHAR_OPEN   = 8'h28;
  localparam logic [7:0] CHAR_CLOSE  = 8'h29;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_PCT    = 8'h25;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] SEP_RESET   = 8'd44;

  typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         format_kind;
  } in_item_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
  } out_item_t;

  // converted request handed from front to back
  typedef struct packed {
    digits_t    digits;
    logic [3:0] nd;
    logic       neg;
    logic [1:0] kind;
  } job_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_CONV,
    FR_HOLD
  } front_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_OPEN,
    BK_DOLLAR,
    BK_SEP,
    BK_DIGIT,
    BK_PCT,
    BK_CLOSE
  } back_state_t;

endpackage

// ===== hdl/itfd_front.sv =====
// itfd_front: accepts a request, takes the magnitude and converts it to
// bcd digits with shift-and-add-3, two bits per cycle. Uses itfd_pkg.
`timescale 1ns / 1ps

module itfd_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  itfd_pkg::in_item_t in_data,
  input  logic             q_full,
  output logic             q_push,
  output itfd_pkg::job_t   q_data
);
  import itfd_pkg::*;

  front_state_t state_r, state_nxt;
  logic [3:0]   cnt_r, cnt_nxt;
  logic [31:0]  mag_r, mag_nxt;
  digits_t      bcd_r, bcd_nxt;
  logic         neg_r, neg_nxt;
  logic [1:0]   kind_r, kind_nxt;
  logic [3:0]   nd;
  logic         accept;

  // one shift-and-add-3 step over all digits
  function automatic digits_t dabble(input digits_t d, input logic b);
    digits_t t;
    logic [NUM_DIGITS*DIGIT_W-1:0] flat;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      t[k] = (d[k] >= 4'd5) ? d[k] + 4'd3 : d[k];
    end
    flat = t;
    return {flat[NUM_DIGITS*DIGIT_W-2:0], b};
  endfunction

  // digit count: highest nonzero digit, at least one
  always_comb begin
    nd = 4'd1;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      if (bcd_r[k] != '0) nd = 4'(k + 1);
    end
  end

  assign q_data = '{digits: bcd_r, nd: nd, neg: neg_r, kind: kind_r};

  // sequencer: idle, convert, hand over
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    mag_nxt   = mag_r;
    bcd_nxt   = bcd_r;
    neg_nxt   = neg_r;
    kind_nxt  = kind_r;
    in_full   = 1'b1;
    q_push    = 1'b0;
    accept    = 1'b0;
    case (state_r)
      FR_IDLE: begin
        in_full = 1'b0;
        accept  = in_push;
      end
      FR_CONV: begin
        bcd_nxt = dabble(dabble(bcd_r, mag_r[31]), mag_r[30]);
        mag_nxt = {mag_r[29:0], 2'b00};
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'(CONV_STEPS - 1)) state_nxt = FR_HOLD;
      end
      FR_HOLD: begin
        in_full = q_full;
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = FR_IDLE;
          accept    = in_push;
        end
      end
      default: state_nxt = FR_IDLE;
    endcase
    // load a new request
    if (accept) begin
      neg_nxt   = in_data.value[31];
      mag_nxt   = in_data.value[31] ? 32'd0 - $unsigned(in_data.value)
                                    : $unsigned(in_data.value);
      bcd_nxt   = '0;
      kind_nxt  = in_data.format_kind;
      cnt_nxt   = 4'd0;
      state_nxt = FR_CONV;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
      cnt_r   <= 4'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    bcd_r  <= bcd_nxt;
    neg_r  <= neg_nxt;
    kind_r <= kind_nxt;
  end

endmodule

// ===== hdl/itfd_queue.sv =====
// itfd_queue: small fifo of converted requests between front and back.
// Uses itfd_pkg for the entry type.
`timescale 1ns / 1ps

module itfd_queue #(
  parameter int DEPTH = itfd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  itfd_pkg::job_t wr_data,
  output logic           full,
  input  logic           pop,
  output itfd_pkg::job_t rd_data,
  output logic           empty
);
  import itfd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             entry_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, rptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = entry_r[rptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) wptr_r <= (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      if (do_pop)  rptr_r <= (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) entry_r[wptr_r] <= wr_data;
  end

endmodule

// ===== hdl/itfd_back.sv =====
// itfd_back: holds the separator register; walks a converted request, emits its
// characters to the output register, one per cycle unless stalled. Uses itfd_pkg.
`timescale 1ns / 1ps

module itfd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [7:0]           cfg_wr_data,
  input  logic                 q_empty,
  input  itfd_pkg::job_t       q_data,
  output logic                 q_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output itfd_pkg::out_item_t  out_data
);
  import itfd_pkg::*;

  back_state_t state_r, state_nxt, after;
  job_t        job_r, job_nxt;
  logic [3:0]  idx_r, idx_nxt, idx_after, dsel;
  out_item_t   out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  sep_r;
  logic [7:0]  ch;
  logic        emit, advance, load_ok;

  // entry state of a request
  function automatic back_state_t first_state(input job_t j);
    if (j.neg) return BK_OPEN;
    if (j.kind == FMT_DOLLAR) return BK_DOLLAR;
    return BK_DIGIT;
  endfunction

  // state after the last digit
  function automatic back_state_t tail_state(input job_t j);
    if (j.kind == FMT_PERCENT) return BK_PCT;
    if (j.neg) return BK_CLOSE;
    return BK_IDLE;
  endfunction

  assign advance   = !out_valid_r || out_pop;
  assign dsel      = idx_r - 4'd1;
  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

  // character selection and sequencing
  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    idx_nxt       = idx_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_pop;
    q_pop         = 1'b0;
    emit          = 1'b1;
    ch            = CHAR_ZERO;
    after         = BK_IDLE;
    idx_after     = idx_r;
    case (state_r)
      BK_IDLE: emit = 1'b0;
      BK_OPEN: begin
        ch    = CHAR_OPEN;
        after = (job_r.kind == FMT_DOLLAR) ? BK_DOLLAR : BK_DIGIT;
      end
      BK_DOLLAR: begin
        ch    = CHAR_DOLLAR;
        after = BK_DIGIT;
      end
      BK_SEP: begin
        ch    = sep_r;
        after = BK_DIGIT;
      end
      BK_DIGIT: begin
        ch = CHAR_ZERO + {4'b0000, job_r.digits[dsel]};
        if (idx_r == 4'd1) begin
          after = tail_state(job_r);
        end else begin
          idx_after = idx_r - 4'd1;
          after = (job_r.kind != FMT_NOSEP &&
                   (idx_after == 4'd3 || idx_after == 4'd6 || idx_after == 4'd9))
                  ? BK_SEP : BK_DIGIT;
        end
      end
      BK_PCT: begin
        ch    = CHAR_PCT;
        after = job_r.neg ? BK_CLOSE : BK_IDLE;
      end
      BK_CLOSE: begin
        ch    = CHAR_CLOSE;
        after = BK_IDLE;
      end
      default: emit = 1'b0;
    endcase

    if (emit && advance) begin
      out_nxt       = '{text_char: ch, last_char: (after == BK_IDLE)};
      out_valid_nxt = 1'b1;
      state_nxt     = after;
      idx_nxt       = idx_after;
    end

    // pick up the next request as soon as this one ends
    load_ok = (state_r == BK_IDLE) || (emit && advance && after == BK_IDLE);
    if (load_ok && !q_empty) begin
      q_pop     = 1'b1;
      job_nxt   = q_data;
      state_nxt = first_state(q_data);
      idx_nxt   = q_data.nd;
    end
  end

  // control registers and separator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      idx_r       <= 4'd1;
      sep_r       <= SEP_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      if (cfg_wr_en) sep_r <= cfg_wr_data;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    out_r <= out_nxt;
  end

  // digit position stays within the ten digits
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DIGIT || state_r == BK_SEP) |-> (idx_r >= 4'd1 && idx_r <= 4'd10))
    else $error("digit position out of range");

  // a separator is always followed by a digit
  a_sep_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_SEP && advance) |=> (state_r == BK_DIGIT))
    else $error("separator not followed by digit");

  // no new request is taken while a character is blocked and the walk is not idle
  a_no_pop_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_pop && state_r != BK_IDLE) |-> !q_pop)
    else $error("request taken while output stalled");

  // a bracketed number ends in a closing bracket
  a_close_last: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && advance && after == BK_IDLE && job_r.neg) |-> (ch == CHAR_CLOSE))
    else $error("negative text does not end in bracket");

endmodule

// ===== hdl/integer_to_formatted_decimal_top.sv =====
// integer_to_formatted_decimal_top: formatted decimal text generator.
// Instantiates itfd_front, itfd_queue and itfd_back; uses itfd_pkg.
//
// Usage:
//   Input queue: present value and format_kind on in_data with in_push; the
//   request is taken on a clock edge where in_full is low. Output queue: while
//   out_empty is low, out_data holds the next character; pulse out_pop to take
//   it. last_char marks the final character of each number.
//   Configuration: cfg_wr_en with cfg_wr_data sets the group separator; write
//   only while no request is in flight.
// Path: an accepted request passes the conversion, the hand-over into the
//   request queue, the load into the back and the output register.
// Throughput: the front converts two magnitude bits per cycle and takes the next
//   request only as it hands over the current one; the back emits one character
//   per cycle while out_pop keeps up, 1 to 16 per number.
// Reset: synchronous, active low; all queues empty, separator back to ','.
// Stall: a character waiting on out_pop holds the back; the request queue then
//   fills and the front raises in_full after its current conversion.
`timescale 1ns / 1ps

module integer_to_formatted_decimal_top #(
  parameter int QUEUE_DEPTH = itfd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  itfd_pkg::in_item_t  in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output itfd_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data
);
  import itfd_pkg::*;

  logic q_push, q_full, q_pop, q_empty;
  job_t q_wr_data, q_rd_data;

  // classify and convert
  itfd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wr_data)
  );

  // request queue between front and back
  itfd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  // character emission
  itfd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_empty     (q_empty),
    .q_data      (q_rd_data),
    .q_pop       (q_pop),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_data    (out_data)
  );

endmodule
